@@ rtl/kpmt_pkg.sv @@
// ----------------------------------------------------------------------------
// kpmt_pkg: shared definitions for the keypad scanner with multi-tap entry
// Register indexes, reset values, key codes and the key-map result struct.
// ----------------------------------------------------------------------------
package kpmt_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_ENTRY_ENABLE   = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd1;
	localparam logic [1:0] REG_COMMIT_TIMEOUT = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd64;
	localparam logic [15:0] COMMIT_TIMEOUT_RST = 16'd4000;

	// Key indexes with special handling
	localparam logic [4:0] KEY_NONE    = 5'd0;
	localparam logic [4:0] KEY_ONE     = 5'd1;
	localparam logic [4:0] KEY_PQRS    = 5'd7;
	localparam logic [4:0] KEY_WXYZ    = 5'd9;
	localparam logic [4:0] KEY_ZERO    = 5'd11;
	localparam logic [4:0] KEY_BLOCKED = 5'd12;

	// Row drive patterns
	localparam logic [3:0] ROW_FIRST = 4'b0001;
	localparam logic [3:0] ROW_SECOND = 4'b0010;
	localparam logic [3:0] ROW_TOP = 4'b1000;

	// What the key map hands to the scan machine
	typedef struct packed {
		logic [4:0] scan_key;   // key under the driven row and sensed column
		logic [2:0] next_tap;   // tap index after one more press of the pending key
		logic [7:0] char_code;  // character of the pending key at its current tap
	} kpmt_key_info_t;

endpackage

@@ rtl/kpmt_key_map.sv @@
// ----------------------------------------------------------------------------
// kpmt_key_map: key index, multi-tap advance and character decode
// Maps the driven row and column code to a key, steps the tap index of the
// pending key and decodes the pending key and tap into a character code.
// ----------------------------------------------------------------------------
module kpmt_key_map (
	input  logic [3:0]              row_pattern,
	input  logic [2:0]              column_sense,
	input  logic [4:0]              pending_key,
	input  logic [2:0]              tap_index,
	output kpmt_pkg::kpmt_key_info_t info
);
	import kpmt_pkg::*;

	logic [2:0] col_code;
	logic [2:0] tap_top;
	logic [7:0] k8;
	logic [7:0] t8;
	logic [4:0] scan_key;
	logic [2:0] next_tap;
	logic [7:0] char_code;

	assign k8 = {3'b000, pending_key};
	assign t8 = {5'b00000, tap_index};

	// Key index: column code four reads as three, row adds an offset
	always_comb begin
		col_code = (column_sense == 3'd4) ? 3'd3 : column_sense;
		case (row_pattern)
			ROW_TOP:    scan_key = {2'b00, col_code};
			ROW_FIRST:  scan_key = {2'b00, col_code} + 5'd3;
			ROW_SECOND: scan_key = {2'b00, col_code} + 5'd6;
			default:    scan_key = {2'b00, col_code} + 5'd9;
		endcase
	end

	// Tap cycle: wrap to the digit past the last letter of the key
	always_comb begin
		if (pending_key == KEY_ZERO)
			tap_top = 3'd2;
		else if (pending_key == KEY_PQRS || pending_key == KEY_WXYZ)
			tap_top = 3'd4;
		else
			tap_top = 3'd3;
		if (pending_key == KEY_ONE || tap_index >= tap_top)
			next_tap = 3'd0;
		else
			next_tap = tap_index + 3'd1;
	end

	// Character decode, modulo 256
	always_comb begin
		if (tap_index == 3'd0) begin
			char_code = (pending_key == KEY_ZERO) ? 8'h30 : k8 + 8'h30;
		end else begin
			case (pending_key)
				5'd2, 5'd3, 5'd4, KEY_PQRS:
					char_code = 8'((k8 - 8'd2) * 8'd3) + t8 + 8'h40;
				KEY_WXYZ:
					char_code = 8'd21 + t8 + 8'h41;
				5'd5, 5'd6:
					char_code = 8'((k8 - 8'd3) * 8'd3) + t8 + 8'h43;
				KEY_ZERO:
					char_code = 8'h20;
				default:
					char_code = {k8[5:0], 2'b00} + t8 + 8'd51;
			endcase
		end
	end

	assign info = {scan_key, next_tap, char_code};

endmodule

@@ rtl/keypad_scan_multitap_entry.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_multitap_entry: 4x3 keypad scanner with multi-tap text entry
// Scans a matrix keypad one tick per request, debounces press and release,
// and commits multi-tap characters on timeout or on a different key.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one scan tick carrying the sensed column
// bits for the row currently driven and a flag that clears the character
// counter. Every tick yields exactly one response on the master stream with the
// row drive to apply next, the committed character (tuser high when one was
// committed this tick), the character and held-key counters, and the pending
// key and tap. The block takes one request per clock cycle: the whole state
// update for a tick is combinational logic between the input register and
// the response register, and the scan state feeds back into the next tick in
// that same cycle. A request passes through the input register and then the
// response register. A stalled master side holds the response register and
// backs up into the input register; requests keep flowing as soon as the
// response is taken. The configuration registers (entry enable, debounce limit,
// commit timeout) are written through the plain write port and take effect on
// the next tick; write them only while no tick is in flight.
// ----------------------------------------------------------------------------
module keypad_scan_multitap_entry (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [kpmt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// Tick requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] column_sense, [3] clear_count, [7:4] zero
	// Scan responses
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] row_drive, [11:4] char_code, [19:12] char_count,
	                               // [27:20] held_count, [32:28] current_key,
	                               // [35:33] current_tap, [39:36] zero
	output logic        m_tuser    // [0] char_valid
);
	import kpmt_pkg::*;

	typedef enum logic [1:0] {
		PH_ROTATE,
		PH_ARM,
		PH_PRESS,
		PH_RELEASE
	} phase_t;

	// Configuration registers
	logic        entry_enable_q;
	logic [7:0]  debounce_limit_q;
	logic [15:0] commit_timeout_q;

	// Input stage
	logic        valid_s1;
	logic [2:0]  cols_s1;
	logic        clear_s1;
	logic        advance;

	// Scan state
	phase_t      phase_q, phase_n;
	logic [3:0]  row_q, row_n;
	logic [4:0]  key_q, key_n;
	logic [2:0]  tap_q, tap_n;
	logic [7:0]  count_q, count_n;
	logic [7:0]  balance_q, balance_n;
	logic [7:0]  debounce_q, debounce_n;
	logic [15:0] idle_q, idle_n;

	// Response register
	logic        char_valid_q;
	logic [7:0]  char_code_q;
	logic        emit;

	kpmt_key_info_t info;

	kpmt_key_map u_key_map (
		.row_pattern  (row_q),
		.column_sense (cols_s1),
		.pending_key  (key_q),
		.tap_index    (tap_q),
		.info         (info)
	);

	// Move the held tick into the response register when that register frees up
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_enable_q   <= 1'b0;
			debounce_limit_q <= DEBOUNCE_LIMIT_RST;
			commit_timeout_q <= COMMIT_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_ENTRY_ENABLE:   entry_enable_q   <= cfg_wdata[0];
				REG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_wdata[7:0];
				REG_COMMIT_TIMEOUT: commit_timeout_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Capture the tick request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cols_s1  <= s_tdata[2:0];
			clear_s1 <= s_tdata[3];
		end
	end

	// One tick of the scan machine
	always_comb begin
		phase_n    = phase_q;
		row_n      = row_q;
		key_n      = key_q;
		tap_n      = tap_q;
		balance_n  = balance_q;
		emit       = 1'b0;
		// Clear the counter first, then advance both timers with saturation
		count_n    = clear_s1 ? 8'd0 : count_q;
		debounce_n = (debounce_q == 8'hFF) ? debounce_q : debounce_q + 8'd1;
		idle_n     = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

		case (phase_q)
			PH_ROTATE: begin
				row_n   = row_q[3] ? ROW_FIRST : {row_q[2:0], 1'b0};
				phase_n = PH_ARM;
			end
			PH_ARM: begin
				// Commit the pending key once the idle timeout has passed
				if (key_q != KEY_NONE) begin
					if (idle_n >= commit_timeout_q && entry_enable_q &&
					    key_q != KEY_BLOCKED) begin
						emit  = 1'b1;
						key_n = KEY_NONE;
					end
				end else begin
					idle_n = 16'd0;
				end
				if (cols_s1 != 3'd0) begin
					debounce_n = 8'd0;
					phase_n    = PH_PRESS;
				end else begin
					phase_n = PH_ROTATE;
				end
			end
			PH_PRESS: begin
				if (debounce_n >= debounce_limit_q) begin
					if (cols_s1 == 3'd0) begin
						phase_n = PH_ROTATE;
					end else begin
						balance_n  = balance_q + 8'd1;
						debounce_n = 8'd0;
						if (key_q == KEY_NONE) begin
							key_n = info.scan_key;
						end else if (key_q == info.scan_key) begin
							tap_n = info.next_tap;
						end else begin
							// Different key: commit the old one, start over
							if (entry_enable_q && key_q != KEY_BLOCKED)
								emit = 1'b1;
							idle_n = 16'd0;
							key_n  = info.scan_key;
						end
						phase_n = PH_RELEASE;
					end
				end
			end
			PH_RELEASE: begin
				if (debounce_n >= debounce_limit_q) begin
					if (cols_s1 == 3'd0) begin
						balance_n = balance_q - 8'd1;
						phase_n   = PH_ARM;
					end else begin
						debounce_n = 8'd0;
					end
				end
			end
			default: phase_n = PH_ROTATE;
		endcase

		if (emit) begin
			count_n = count_n + 8'd1;
			tap_n   = 3'd0;
		end
	end

	// Scan state and response control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ROTATE;
			row_q      <= ROW_FIRST;
			key_q      <= KEY_NONE;
			tap_q      <= 3'd0;
			count_q    <= 8'd0;
			balance_q  <= 8'd0;
			debounce_q <= 8'd0;
			idle_q     <= 16'd0;
			m_tvalid   <= 1'b0;
		end else begin
			if (advance) begin
				phase_q    <= phase_n;
				row_q      <= row_n;
				key_q      <= key_n;
				tap_q      <= tap_n;
				count_q    <= count_n;
				balance_q  <= balance_n;
				debounce_q <= debounce_n;
				idle_q     <= idle_n;
				m_tvalid   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid   <= 1'b0;
			end
		end
	end

	// Character payload of the response
	always_ff @(posedge clk) begin
		if (advance) begin
			char_valid_q <= emit;
			char_code_q  <= emit ? info.char_code : 8'd0;
		end
	end

	assign m_tuser = char_valid_q;
	assign m_tdata = {4'b0000, tap_q, key_q, balance_q, count_q, char_code_q, row_q};

endmodule
